// ----- sv/rsd_pkg.sv -----
// Shared types and constants for the run-length sprite row decoder.
// Item structs, status and mode codes, register indexes and the queue entry.
// No dependencies.
`default_nettype none

package rsd_pkg;

  localparam int unsigned FW_W        = 11;
  localparam int unsigned FH_W        = 8;
  localparam int unsigned X_W         = 10;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 11;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned PAL_ENTRIES = 256;
  localparam int unsigned PAL_ADDR_W  = 8;
  localparam int unsigned RGB_W       = 24;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd320;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 8'd200;
  localparam logic [7:0]      ROW_END          = 8'hFF;
  localparam int unsigned     FLAG_X_HIGH_BIT  = 0;
  localparam int unsigned     FLAG_LAST_BIT    = 7;
  localparam int unsigned     X_HIGH_OFFSET    = 256;

  typedef enum logic [1:0] {
    MODE_PAL    = 2'd0,
    MODE_STREAM = 2'd1,
    MODE_START  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_SPAN    = 2'd0,
    ST_DONE    = 2'd1,
    ST_ROW_ERR = 2'd2,
    ST_X_ERR   = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OP_PAL_WRITE = 2'd0,
    OP_SPAN      = 2'd1,
    OP_STATUS    = 2'd2
  } op_kind_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] pal_addr;
    logic [7:0] pal_red;
    logic [7:0] pal_green;
    logic [7:0] pal_blue;
    logic [7:0] stream_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]     status;
    logic [7:0]     row;
    logic [X_W-1:0] x_start;
    logic [7:0]     run_length;
    logic [7:0]     red;
    logic [7:0]     green;
    logic [7:0]     blue;
  } out_item_t;

  typedef struct packed {
    op_kind_e              kind;
    status_e               status;
    logic [7:0]            row;
    logic [X_W-1:0]        x_start;
    logic [7:0]            run_length;
    logic [PAL_ADDR_W-1:0] pal_addr;
    logic [RGB_W-1:0]      rgb;
  } rsd_op_t;

endpackage

`default_nettype wire

// ----- sv/rsd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rsd_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- sv/rsd_front.sv -----
// Front end: accepts items, holds the configuration registers and the stream parser,
// and turns each item into at most one queue entry. Depends on rsd_pkg.
`default_nettype none

module rsd_front
  import rsd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire in_item_t              in_item_i,
  output logic                       in_stall_o,
  input  wire logic                  cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  q_full_i,
  output logic                       push_o,
  output rsd_op_t                    push_op_o
);

  localparam int unsigned CW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned EW   = CW + 1;
  localparam int unsigned CMPW = (EW > FW_W) ? EW : FW_W;

  typedef enum logic [3:0] {
    PH_ROW     = 4'd0,
    PH_X       = 4'd1,
    PH_FLAGS   = 4'd2,
    PH_SKIP    = 4'd3,
    PH_LEN     = 4'd4,
    PH_CODE    = 4'd5,
    PH_LIT     = 4'd6,
    PH_REP     = 4'd7,
    PH_PENDING = 4'd8
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [FW_W-1:0] width_q;
  logic [FH_W-1:0] height_q;
  logic [7:0]      row_q, row_d;
  logic [7:0]      rows_done_q, rows_done_d;
  logic [CW-1:0]   cursor_q, cursor_d;
  logic            last_q, last_d;
  logic [7:0]      seg_q, seg_d;
  logic [7:0]      run_q, run_d;
  logic            over_q, over_d;

  logic            accept;
  mode_e           mode;
  logic [7:0]      b;
  logic [7:0]      span_len;
  logic [EW-1:0]   span_end;
  logic [CMPW-1:0] lim;
  logic [CMPW-1:0] cursor_ext;
  logic            span_over;
  logic [CW-1:0]   cursor_sat;
  logic [7:0]      seg_dec;
  logic            eos_done;
  phase_e          eos_phase;
  logic            do_finish;
  logic            push;
  rsd_op_t         op;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign mode       = mode_e'(in_item_i.mode);
  assign b          = in_item_i.stream_byte;

  assign span_len   = (phase_q == PH_REP) ? run_q : 8'd1;
  assign span_end   = {1'b0, cursor_q} + EW'(span_len);
  assign lim        = (CMPW'(width_q) > CMPW'(MAX_WIDTH)) ? CMPW'(MAX_WIDTH) : CMPW'(width_q);
  assign span_over  = CMPW'(span_end) > lim;
  assign cursor_sat = (span_end > EW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : span_end[CW-1:0];
  assign cursor_ext = CMPW'(cursor_q);
  assign seg_dec    = seg_q - 8'd1;
  assign eos_done   = last_q && (rows_done_q >= height_q);
  assign eos_phase  = last_q ? PH_ROW : PH_X;

  always_comb begin
    phase_d     = phase_q;
    row_d       = row_q;
    rows_done_d = rows_done_q;
    cursor_d    = cursor_q;
    last_d      = last_q;
    seg_d       = seg_q;
    run_d       = run_q;
    over_d      = over_q;
    do_finish   = 1'b0;
    push        = 1'b0;
    op          = '0;
    op.kind     = OP_STATUS;
    op.status   = ST_SPAN;

    if (accept) begin
      unique case (mode)
        MODE_PAL: begin
          push        = 1'b1;
          op.kind     = OP_PAL_WRITE;
          op.pal_addr = in_item_i.pal_addr;
          op.rgb      = {in_item_i.pal_red, in_item_i.pal_green, in_item_i.pal_blue};
        end
        MODE_START: begin
          phase_d     = PH_ROW;
          row_d       = '0;
          rows_done_d = '0;
          cursor_d    = '0;
          last_d      = 1'b0;
          seg_d       = '0;
          run_d       = '0;
          over_d      = 1'b0;
        end
        MODE_NONE: begin
        end
        MODE_STREAM: begin
          if (!over_q) begin
            unique case (phase_q)
              PH_ROW: begin
                if (b == ROW_END) begin
                  do_finish = 1'b1;
                end else if (b >= height_q) begin
                  over_d    = 1'b1;
                  push      = 1'b1;
                  op.kind   = OP_STATUS;
                  op.status = ST_ROW_ERR;
                  op.row    = b;
                end else begin
                  row_d       = b;
                  rows_done_d = rows_done_q + 8'd1;
                  phase_d     = PH_X;
                end
              end
              PH_X: begin
                cursor_d = CW'(b);
                phase_d  = PH_FLAGS;
              end
              PH_FLAGS: begin
                if (b[FLAG_X_HIGH_BIT]) begin
                  cursor_d = cursor_q + CW'(X_HIGH_OFFSET);
                end
                last_d  = b[FLAG_LAST_BIT];
                phase_d = PH_SKIP;
              end
              PH_SKIP: begin
                phase_d = PH_LEN;
              end
              PH_LEN: begin
                seg_d   = b;
                phase_d = PH_CODE;
                if (b == 8'd0) begin
                  if (eos_done) begin
                    do_finish = 1'b1;
                  end else begin
                    phase_d = eos_phase;
                  end
                end
              end
              PH_CODE: begin
                run_d   = {1'b0, b[7:1]} + 8'd1;
                phase_d = b[0] ? PH_REP : PH_LIT;
                seg_d   = seg_dec;
                if (seg_dec == 8'd0) begin
                  if (eos_done) begin
                    do_finish = 1'b1;
                  end else begin
                    phase_d = eos_phase;
                  end
                end
              end
              PH_LIT, PH_REP: begin
                push          = 1'b1;
                op.row        = row_q;
                op.x_start    = cursor_ext[X_W-1:0];
                op.run_length = span_len;
                if (span_over) begin
                  op.kind   = OP_STATUS;
                  op.status = ST_X_ERR;
                end else begin
                  op.kind     = OP_SPAN;
                  op.status   = ST_SPAN;
                  op.pal_addr = b;
                end
                cursor_d = cursor_sat;
                if (phase_q == PH_REP) begin
                  run_d   = '0;
                  phase_d = PH_CODE;
                end else begin
                  run_d = run_q - 8'd1;
                  if (run_q == 8'd1) begin
                    phase_d = PH_CODE;
                  end
                end
                seg_d = seg_dec;
                if (seg_dec == 8'd0) begin
                  phase_d = eos_done ? PH_PENDING : eos_phase;
                end
              end
              PH_PENDING: begin
                do_finish = 1'b1;
              end
              default: begin
                do_finish = 1'b1;
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end

    if (do_finish) begin
      over_d    = 1'b1;
      phase_d   = PH_ROW;
      push      = 1'b1;
      op        = '0;
      op.kind   = OP_STATUS;
      op.status = ST_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_ROW;
      width_q     <= FRAME_WIDTH_RST;
      height_q    <= FRAME_HEIGHT_RST;
      row_q       <= '0;
      rows_done_q <= '0;
      cursor_q    <= '0;
      last_q      <= 1'b0;
      seg_q       <= '0;
      run_q       <= '0;
      over_q      <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      row_q       <= row_d;
      rows_done_q <= rows_done_d;
      cursor_q    <= cursor_d;
      last_q      <= last_d;
      seg_q       <= seg_d;
      run_q       <= run_d;
      over_q      <= over_d;
      if (cfg_valid_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          CFG_FRAME_WIDTH:  width_q  <= cfg_data_i[FW_W-1:0];
          CFG_FRAME_HEIGHT: height_q <= cfg_data_i[FH_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  assign push_o    = push;
  assign push_op_o = op;

endmodule

`default_nettype wire

// ----- sv/rsd_queue.sv -----
// Short FIFO of decoded operations between the front end and the back end.
// Depends on rsd_pkg.
`default_nettype none

module rsd_queue
  import rsd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire rsd_op_t push_op_i,
  output logic         full_o,
  input  wire logic    pop_i,
  output rsd_op_t      head_o,
  output logic         empty_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  rsd_op_t           entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/rsd_back.sv -----
// Back end: carries out queued operations against the palette RAM and drives
// the output register. Depends on rsd_pkg and rsd_ram.
`default_nettype none

module rsd_back
  import rsd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire rsd_op_t head_i,
  input  wire logic    empty_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output out_item_t    out_item_o
);

  logic             s1_valid_q;
  rsd_op_t          s1_op_q;
  logic             s1_adv;
  logic             pop;
  logic             ram_we, ram_re;
  logic [RGB_W-1:0] rdata;
  logic             out_valid_q;
  out_item_t        out_q;
  logic [RGB_W-1:0] colour;

  assign s1_adv = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign pop    = !empty_i && (!s1_valid_q || s1_adv);
  assign ram_we = pop && (head_i.kind == OP_PAL_WRITE);
  assign ram_re = pop && (head_i.kind == OP_SPAN);
  assign colour = (s1_op_q.kind == OP_SPAN) ? rdata : '0;

  rsd_ram #(
    .WIDTH (RGB_W),
    .DEPTH (PAL_ENTRIES)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (head_i.pal_addr),
    .wdata_i (head_i.rgb),
    .re_i    (ram_re),
    .raddr_i (head_i.pal_addr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (pop && (head_i.kind != OP_PAL_WRITE)) begin
      s1_op_q <= head_i;
    end
    if (s1_adv) begin
      out_q.status     <= s1_op_q.status;
      out_q.row        <= s1_op_q.row;
      out_q.x_start    <= s1_op_q.x_start;
      out_q.run_length <= s1_op_q.run_length;
      out_q.red        <= colour[23:16];
      out_q.green      <= colour[15:8];
      out_q.blue       <= colour[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop && (head_i.kind != OP_PAL_WRITE)) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign pop_o       = pop;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// ----- sv/rle_sprite_row_decoder.sv -----
// Top level of the run-length sprite row decoder.
// Depends on rsd_pkg, rsd_front, rsd_queue and rsd_back.
//
// Takes one item per clock while in_stall_o is low: a palette write, a stream byte,
// a frame restart or an empty item. The front end parses the byte stream and queues
// at most one operation per item; the back end performs palette writes and lookups in
// the palette RAM and presents one span or status result per cycle while the receiver
// does not stall. A result passes through the queue, the registered palette read
// and the output register. A two-entry queue between front and back absorbs
// output stalls, so input is held off only once it is full.
`default_nettype none

module rle_sprite_row_decoder
  import rsd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_item_t              in_item_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_item_t                  out_item_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic    push, q_full, pop, q_empty;
  rsd_op_t push_op, head_op;

  assign cfg_ready_o = 1'b1;

  rsd_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_stall_o  (in_stall_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_op_o   (push_op)
  );

  rsd_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .full_o    (q_full),
    .pop_i     (pop),
    .head_o    (head_op),
    .empty_o   (q_empty)
  );

  rsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_op),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ----- sv/rsd_checker.sv -----
// Port-level checks on the decoder's result channel, bound to the top level.
// Depends on rsd_pkg.
`default_nettype none

module rsd_checker
  import rsd_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      out_valid_i,
  input wire logic      out_stall_i,
  input wire out_item_t out_item_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_item_i))
    else $error("stalled result changed");

  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_item_i.status == ST_DONE) |->
      (out_item_i.row == '0) && (out_item_i.x_start == '0) &&
      (out_item_i.run_length == '0) && (out_item_i.red == '0) &&
      (out_item_i.green == '0) && (out_item_i.blue == '0))
    else $error("frame done result carries data");

  a_row_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_item_i.status == ST_ROW_ERR) |->
      (out_item_i.x_start == '0) && (out_item_i.run_length == '0) &&
      (out_item_i.red == '0) && (out_item_i.green == '0) && (out_item_i.blue == '0))
    else $error("row error result carries span data");

  a_x_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_item_i.status == ST_X_ERR) |->
      (out_item_i.run_length != '0) && (out_item_i.red == '0) &&
      (out_item_i.green == '0) && (out_item_i.blue == '0))
    else $error("x error result malformed");

  a_span_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_item_i.status == ST_SPAN) |->
      (out_item_i.run_length != '0) && (out_item_i.run_length <= 8'd128))
    else $error("span length out of range");

endmodule

bind rle_sprite_row_decoder rsd_checker u_rsd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_i  (out_item_o)
);

`default_nettype wire

// ----- tb/sv/rle_sprite_row_decoder_tb.sv -----
// Self-checking testbench for rle_sprite_row_decoder: directed frames, then random
// frames under several frame sizes, with bursty input and a stalling receiver.
// Depends on rsd_pkg and the decoder RTL.
module rle_sprite_row_decoder_tb;
  import rsd_pkg::*;

  localparam int unsigned MAX_WIDTH    = 1024;
  localparam int unsigned ITEMS_TARGET = 1450;
  localparam int unsigned PHASE_ITEMS  = 150;
  localparam int unsigned HOLD_CYCLES  = 300;

  typedef enum logic [3:0] {
    PARSE_ROW,
    PARSE_X_LOW,
    PARSE_FLAGS,
    PARSE_PAD,
    PARSE_LEN,
    PARSE_CODE,
    PARSE_LITERAL,
    PARSE_REPEAT,
    PARSE_DONE_OWED
  } parse_phase_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_reg_e cfg_index = CFG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rle_sprite_row_decoder #(
    .MAX_WIDTH(MAX_WIDTH)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  in_item_t offer_queue[$];
  out_item_t spans_due[$];
  int items_sent = 0;
  int errors = 0;
  logic item_taken = 1'b0;
  int hold_requests = 0;

  // Decoder state as seen by the predictor
  logic [RGB_W-1:0] pal_rgb [PAL_ENTRIES];
  logic [FW_W-1:0]  width_reg;
  logic [FH_W-1:0]  height_reg;
  parse_phase_e     phase;
  logic [7:0]       row_now;
  logic [7:0]       rows_seen;
  int unsigned      cursor;
  logic             last_seg;
  logic [7:0]       seg_bytes;
  logic [7:0]       run_owed;
  logic             frame_closed;

  function automatic void restart_parser();
    phase = PARSE_ROW;
    row_now = '0;
    rows_seen = '0;
    cursor = 0;
    last_seg = 1'b0;
    seg_bytes = '0;
    run_owed = '0;
    frame_closed = 1'b0;
  endfunction

  function automatic void push_result(status_e st, logic [7:0] row, int unsigned x,
                                      int unsigned len, logic [RGB_W-1:0] rgb);
    out_item_t r;
    r.status = st;
    r.row = row;
    r.x_start = X_W'(x);
    r.run_length = 8'(len);
    {r.red, r.green, r.blue} = rgb;
    spans_due.push_back(r);
  endfunction

  function automatic void frame_finished();
    frame_closed = 1'b1;
    phase = PARSE_ROW;
    push_result(ST_DONE, 8'd0, 0, 0, '0);
  endfunction

  function automatic bit close_segment();
    if (!last_seg) begin
      phase = PARSE_X_LOW;
      return 1'b0;
    end
    if (rows_seen >= height_reg) return 1'b1;
    phase = PARSE_ROW;
    return 1'b0;
  endfunction

  function automatic bit consume_segment_byte();
    seg_bytes = seg_bytes - 8'd1;
    if (seg_bytes == 8'd0) return close_segment();
    return 1'b0;
  endfunction

  function automatic void emit_span(int unsigned len, logic [7:0] idx);
    int unsigned lim;
    int unsigned x0;
    int unsigned stop;
    lim = (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    x0 = cursor;
    stop = x0 + len;
    cursor = (stop > MAX_WIDTH) ? MAX_WIDTH : stop;
    if (stop > lim) push_result(ST_X_ERR, row_now, x0, len, '0);
    else push_result(ST_SPAN, row_now, x0, len, pal_rgb[idx]);
  endfunction

  function automatic void decode_item(in_item_t it);
    logic [7:0] b;
    b = it.stream_byte;
    case (mode_e'(it.mode))
      MODE_PAL: pal_rgb[it.pal_addr] = {it.pal_red, it.pal_green, it.pal_blue};
      MODE_START: restart_parser();
      MODE_STREAM: begin
        if (!frame_closed) begin
          case (phase)
            PARSE_ROW: begin
              if (b == ROW_END) begin
                frame_finished();
              end else if (b >= height_reg) begin
                frame_closed = 1'b1;
                push_result(ST_ROW_ERR, b, 0, 0, '0);
              end else begin
                row_now = b;
                rows_seen = rows_seen + 8'd1;
                phase = PARSE_X_LOW;
              end
            end
            PARSE_X_LOW: begin
              cursor = b;
              phase = PARSE_FLAGS;
            end
            PARSE_FLAGS: begin
              if (b[FLAG_X_HIGH_BIT]) cursor = cursor + X_HIGH_OFFSET;
              last_seg = b[FLAG_LAST_BIT];
              phase = PARSE_PAD;
            end
            PARSE_PAD: phase = PARSE_LEN;
            PARSE_LEN: begin
              seg_bytes = b;
              phase = PARSE_CODE;
              if (b == 8'd0) begin
                if (close_segment()) frame_finished();
              end
            end
            PARSE_CODE: begin
              run_owed = {1'b0, b[7:1]} + 8'd1;
              phase = b[0] ? PARSE_REPEAT : PARSE_LITERAL;
              if (consume_segment_byte()) frame_finished();
            end
            PARSE_LITERAL: begin
              emit_span(1, b);
              run_owed = run_owed - 8'd1;
              if (run_owed == 8'd0) phase = PARSE_CODE;
              if (consume_segment_byte()) phase = PARSE_DONE_OWED;
            end
            PARSE_REPEAT: begin
              emit_span(run_owed, b);
              run_owed = '0;
              phase = PARSE_CODE;
              if (consume_segment_byte()) phase = PARSE_DONE_OWED;
            end
            default: frame_finished();
          endcase
        end
      end
      default: ;
    endcase
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk or negedge rst_n) begin : check_blk
    out_item_t want;
    if (!rst_n) begin
      restart_parser();
      width_reg = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      item_taken <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (spans_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected item, expected none actual %h", $time, out_item);
        end else begin
          want = spans_due.pop_front();
          compare_field("status", want.status, out_item.status);
          compare_field("row", want.row, out_item.row);
          compare_field("x_start", want.x_start, out_item.x_start);
          compare_field("run_length", want.run_length, out_item.run_length);
          compare_field("red", want.red, out_item.red);
          compare_field("green", want.green, out_item.green);
          compare_field("blue", want.blue, out_item.blue);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FRAME_WIDTH) width_reg = cfg_data[FW_W-1:0];
        else height_reg = cfg_data[FH_W-1:0];
      end
      if (in_valid && !in_stall) decode_item(in_item);
      item_taken <= in_valid && !in_stall;
    end
  end

  // Sender: bursts of items with gaps between them
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin
    if (rst_n && (!in_valid || item_taken)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (offer_queue.size() != 0) begin
        in_item <= offer_queue.pop_front();
        in_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 9) == 0) ? 120 : $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall style changes whenever the 8-bit tick counter wraps; long holds on request
  logic [7:0] stall_tick = '0;
  int stall_style = 0;
  int hold_left = 0;
  int holds_served = 0;

  always @(negedge clk) begin : stall_blk
    logic pattern;
    stall_tick++;
    if (stall_tick == 8'd0) stall_style = $urandom_range(0, 3);
    if (hold_left != 0) begin
      hold_left--;
    end else if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
    end
    case (stall_style)
      1: pattern = ($urandom_range(0, 3) == 0);
      2: pattern = ($urandom_range(0, 3) != 0);
      3: pattern = (stall_tick[2:0] < 3'd3);
      default: pattern = 1'b0;
    endcase
    out_stall <= (hold_left != 0) || pattern;
  end

  task automatic queue_item(mode_e m, logic [7:0] b);
    in_item_t it;
    it.mode = m;
    it.pal_addr = 8'($urandom);
    it.pal_red = 8'($urandom);
    it.pal_green = 8'($urandom);
    it.pal_blue = 8'($urandom);
    it.stream_byte = b;
    offer_queue.push_back(it);
    if (m != MODE_NONE) items_sent++;
  endtask

  task automatic queue_pal(logic [7:0] idx, logic [RGB_W-1:0] rgb);
    in_item_t it;
    it.mode = MODE_PAL;
    it.pal_addr = idx;
    {it.pal_red, it.pal_green, it.pal_blue} = rgb;
    it.stream_byte = 8'($urandom);
    offer_queue.push_back(it);
    items_sent++;
  endtask

  task automatic queue_segment(bit last);
    logic [7:0] body[$];
    logic [7:0] code;
    logic [7:0] len;
    int n;
    int ncodes;
    int keep;
    ncodes = $urandom_range(0, 4);
    for (int c = 0; c < ncodes; c++) begin
      code = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9));
      n = code[0] ? 1 : int'(code[7:1]) + 1;
      if (body.size() + 1 + n > 255) break;
      body.push_back(code);
      repeat (n) body.push_back(8'($urandom));
    end
    // cut the segment short so a pending run is dropped
    if (body.size() != 0 && $urandom_range(0, 4) == 0) begin
      keep = $urandom_range(0, body.size() - 1);
      while (body.size() > keep) void'(body.pop_back());
    end
    len = 8'(body.size());
    if ($urandom_range(0, 19) == 0) len = 8'($urandom);
    queue_item(MODE_STREAM, ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                        : 8'($urandom_range(0, 63)));
    queue_item(MODE_STREAM, {last, 6'($urandom), 1'($urandom_range(0, 3) == 0)});
    queue_item(MODE_STREAM, 8'($urandom));
    queue_item(MODE_STREAM, len);
    foreach (body[i]) queue_item(MODE_STREAM, body[i]);
  endtask

  task automatic queue_frame(int unsigned height_now);
    int nrows;
    int nseg;
    logic [7:0] row;
    queue_item(MODE_START, 8'($urandom));
    nrows = $urandom_range(1, 5);
    for (int r = 0; r < nrows; r++) begin
      if (height_now <= 254 && $urandom_range(0, 24) == 0)
        row = 8'($urandom_range(height_now, 254));
      else
        row = 8'($urandom_range(0, height_now - 1));
      queue_item(MODE_STREAM, row);
      nseg = $urandom_range(1, 3);
      for (int s = 0; s < nseg; s++) queue_segment(s == nseg - 1);
    end
    case ($urandom_range(0, 3))
      0, 1: queue_item(MODE_STREAM, ROW_END);
      2: ;
      default: repeat ($urandom_range(1, 3)) queue_item(MODE_STREAM, 8'($urandom));
    endcase
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_quiet();
    do @(posedge clk); while (offer_queue.size() != 0 || in_valid);
    do @(negedge clk); while (spans_due.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [7:0] opening_bytes [19] = '{
      8'd0, 8'h3E, 8'h80, 8'hFF, 8'd6, 8'h02, 8'h00, 8'hFF, 8'h01, 8'h5A, 8'hFF,
      8'd199, 8'hFF, 8'h81, 8'h00, 8'd2, 8'h01, 8'hFF,
      8'd200
    };
    int unsigned width_plan [8] = '{1024, 1, 320, 0, 2047, 64, 700, 16};
    int unsigned height_plan [8] = '{255, 1, 200, 3, 2, 8, 255, 1};
    logic [7:0] order [PAL_ENTRIES];
    logic [7:0] swap;
    int j;
    int phase_no;
    int phase_end;
    int unsigned w;
    int unsigned h;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    queue_pal(8'h00, 24'h000000);
    queue_pal(8'hFF, 24'hFFFFFF);
    queue_pal(8'h5A, 24'h123456);
    queue_item(MODE_NONE, 8'hFF);
    queue_item(MODE_START, 8'h00);
    foreach (opening_bytes[i]) queue_item(MODE_STREAM, opening_bytes[i]);
    queue_item(MODE_START, 8'hFF);
    queue_item(MODE_STREAM, ROW_END);
    wait_quiet();

    // load every palette entry in shuffled order
    @(posedge clk);
    foreach (order[i]) order[i] = 8'(i);
    for (int i = PAL_ENTRIES - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      swap = order[i];
      order[i] = order[j];
      order[j] = swap;
    end
    foreach (order[i]) queue_pal(order[i], 24'($urandom));
    wait_quiet();

    phase_no = 0;
    while (items_sent < ITEMS_TARGET) begin
      if (phase_no < 8) begin
        w = width_plan[phase_no];
        h = height_plan[phase_no];
      end else begin
        w = $urandom_range(1, MAX_WIDTH);
        h = $urandom_range(1, 255);
      end
      write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(w));
      write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
      @(posedge clk);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        case ($urandom_range(0, 19))
          15, 16, 17: queue_pal(8'($urandom), 24'($urandom));
          18, 19: repeat ($urandom_range(1, 8))
            queue_item(mode_e'($urandom_range(0, 3)), 8'($urandom));
          default: queue_frame(h);
        endcase
      end
      if (phase_no % 3 == 1) hold_requests++;
      phase_no++;
      wait_quiet();
    end

    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

endmodule
